// ===== design/sppw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled pixel pack writer package
// Widths, register indexes, pixel formats and the pipeline word of the
// frame-buffer pixel writer; the widths are shared with its coordinate divider.
// ----------------------------------------------------------------------------
package sppw_pkg;

    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int CH_W      = 8;
    localparam int PROD_W    = COORD_W + DIM_W;
    localparam int QUO_W     = DIM_W;
    localparam int OFF_W     = 26;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 3;
    localparam int FMT_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_DIM   = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT  = 3'd0,
        CFG_SCALE_ENABLE  = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_SOURCE_WIDTH  = 3'd4,
        CFG_SOURCE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGB565 = 2'd0,
        FMT_RGB888 = 2'd1,
        FMT_RGBA   = 2'd2
    } t_fmt;

    localparam logic [CNT_W-1:0] BYTES_RGB565 = 3'd2;
    localparam logic [CNT_W-1:0] BYTES_RGB888 = 3'd3;
    localparam logic [CNT_W-1:0] BYTES_RGBA   = 3'd4;

    typedef struct packed {
        logic               vld;
        logic               drop;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   nbytes;
    } t_side;

endpackage
`default_nettype wire

// ===== design/sppw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined coordinate divider
// Restoring division with one quotient bit per register stage. The caller
// guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module sppw_div (
    input  wire logic                        i_clk,
    input  wire logic [sppw_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [sppw_pkg::DIM_W-1:0]  i_divisor,
    output logic      [sppw_pkg::QUO_W-1:0]  o_quotient
);

    localparam int QW    = sppw_pkg::QUO_W;
    localparam int PW    = sppw_pkg::PROD_W;
    localparam int REM_W = sppw_pkg::DIM_W;

    logic [REM_W-1:0] r_rem [QW];
    logic [PW-1:0]    r_num [QW];
    logic [QW-1:0]    r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [REM_W-1:0] w_rem_in;
        logic [PW-1:0]    w_num_in;
        logic [QW-1:0]    w_quo_in;
        logic [REM_W:0]   w_trial;
        logic [REM_W-1:0] n_rem;
        logic [QW-1:0]    n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = REM_W'(i_dividend[PW-1:QW]);
            assign w_num_in = i_dividend;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        always_comb begin
            w_trial = {w_rem_in, w_num_in[QW-1-k]};
            n_quo   = w_quo_in;
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem            = REM_W'(w_trial - {1'b0, i_divisor});
                n_quo[QW-1-k]    = 1'b1;
            end else begin
                n_rem = w_trial[REM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_num[k] <= w_num_in;
            r_quo[k] <= n_quo;
        end
    end

    assign o_quotient = r_quo[QW-1];

endmodule
`default_nettype wire

// ===== design/scaled_pixel_pack_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled pixel pack writer
// Maps decoded pixels by nearest-neighbor scaling into a target frame and
// produces frame-buffer writes packed as RGB565, RGB888 or RGBA.
// ----------------------------------------------------------------------------
// A pixel word is taken at a rising edge where start is high and busy is low.
// Registers are written through the cfg channel (index, data, valid, ready);
// cfg_ready is always high, and registers must only change while no pixel is
// in flight. Dimension writes above the maximum saturate to it.
// Each kept pixel produces one write word on o_byte_offset, o_write_data and
// o_byte_count, shown for exactly one cycle with o_strobe high. Pixels that
// lie outside the source frame (target frame if unscaled) produce nothing.
// A new pixel is accepted every cycle while busy is low. It passes the input,
// product, 13-stage pipelined divider, select, row, index and output stages;
// the divider scales the coordinates and runs even when scaling is disabled.
// Synchronous reset clears the pipeline and restores the register defaults;
// busy is high for the first cycle after reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
module scaled_pixel_pack_writer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [sppw_pkg::COORD_W-1:0]   i_pixel_x,
    input  wire logic [sppw_pkg::COORD_W-1:0]   i_pixel_y,
    input  wire logic [sppw_pkg::CH_W-1:0]      i_red,
    input  wire logic [sppw_pkg::CH_W-1:0]      i_green,
    input  wire logic [sppw_pkg::CH_W-1:0]      i_blue,
    input  wire logic [sppw_pkg::CH_W-1:0]      i_alpha,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sppw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sppw_pkg::DIM_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output logic      [sppw_pkg::OFF_W-1:0]     o_byte_offset,
    output logic      [sppw_pkg::DATA_W-1:0]    o_write_data,
    output logic      [sppw_pkg::CNT_W-1:0]     o_byte_count
);

    localparam int DW  = sppw_pkg::DIM_W;
    localparam int PW  = sppw_pkg::PROD_W;
    localparam int OW  = sppw_pkg::OFF_W;
    localparam int DLY = sppw_pkg::QUO_W;

    logic [sppw_pkg::FMT_W-1:0] r_fmt;
    logic                       r_scale;
    logic [DW-1:0]              r_tw;
    logic [DW-1:0]              r_th;
    logic [DW-1:0]              r_sw;
    logic [DW-1:0]              r_sh;
    logic [DW-1:0]              w_dim_clamped;
    logic                       r_busy;
    logic                       w_accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;
    assign w_accept    = start && !r_busy;

    always_comb begin
        w_dim_clamped = i_cfg_data;
        if (i_cfg_data > DW'(sppw_pkg::MAX_DIM)) begin
            w_dim_clamped = DW'(sppw_pkg::MAX_DIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= sppw_pkg::FMT_RGB565;
            r_scale <= 1'b0;
            r_tw    <= DW'(1);
            r_th    <= DW'(1);
            r_sw    <= DW'(1);
            r_sh    <= DW'(1);
            r_busy  <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    sppw_pkg::CFG_PIXEL_FORMAT: begin
                        r_fmt <= i_cfg_data[sppw_pkg::FMT_W-1:0];
                    end
                    sppw_pkg::CFG_SCALE_ENABLE:  r_scale <= i_cfg_data[0];
                    sppw_pkg::CFG_TARGET_WIDTH:  r_tw    <= w_dim_clamped;
                    sppw_pkg::CFG_TARGET_HEIGHT: r_th    <= w_dim_clamped;
                    sppw_pkg::CFG_SOURCE_WIDTH:  r_sw    <= w_dim_clamped;
                    sppw_pkg::CFG_SOURCE_HEIGHT: r_sh    <= w_dim_clamped;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Input stage: capture coordinates and pack the pixel.
    logic [sppw_pkg::DATA_W-1:0] n_data;
    logic [sppw_pkg::CNT_W-1:0]  n_nbytes;
    sppw_pkg::t_side             r_s1;

    always_comb begin
        case (r_fmt)
            sppw_pkg::FMT_RGB888: begin
                n_data   = {8'h00, i_blue, i_green, i_red};
                n_nbytes = sppw_pkg::BYTES_RGB888;
            end
            sppw_pkg::FMT_RGBA: begin
                n_data   = {i_alpha, i_blue, i_green, i_red};
                n_nbytes = sppw_pkg::BYTES_RGBA;
            end
            default: begin
                n_data   = {16'h0000, i_red[7:3], i_green[7:2], i_blue[7:3]};
                n_nbytes = sppw_pkg::BYTES_RGB565;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s1.drop   <= 1'b0;
        r_s1.x      <= i_pixel_x;
        r_s1.y      <= i_pixel_y;
        r_s1.data   <= n_data;
        r_s1.nbytes <= n_nbytes;
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= w_accept;
        end
    end

    // Scale products and frame bounds check.
    logic [PW-1:0]     r_px;
    logic [PW-1:0]     r_py;
    sppw_pkg::t_side   r_s2;
    sppw_pkg::t_side   n_s2;
    logic              n_drop;

    always_comb begin
        if (r_scale) begin
            n_drop = ({1'b0, r_s1.x} >= r_sw) || ({1'b0, r_s1.y} >= r_sh);
        end else begin
            n_drop = ({1'b0, r_s1.x} >= r_tw) || ({1'b0, r_s1.y} >= r_th);
        end
        n_drop = n_drop || (r_tw == '0) || (r_th == '0);
        n_s2      = r_s1;
        n_s2.drop = n_drop;
        if (!i_rst_n) begin
            n_s2.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= PW'(r_s1.x) * PW'(r_tw);
        r_py <= PW'(r_s1.y) * PW'(r_th);
        r_s2 <= n_s2;
    end

    // Coordinate dividers with the side word delayed alongside.
    logic [DW-1:0]   w_qx;
    logic [DW-1:0]   w_qy;
    sppw_pkg::t_side r_dly [DLY];

    sppw_div u_div_x (
        .i_clk      (i_clk),
        .i_dividend (r_px),
        .i_divisor  (r_sw),
        .o_quotient (w_qx)
    );

    sppw_div u_div_y (
        .i_clk      (i_clk),
        .i_dividend (r_py),
        .i_divisor  (r_sh),
        .o_quotient (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_dly[i] <= '0;
            end
        end else begin
            r_dly[0] <= r_s2;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // Coordinate select, row product, linear index, byte offset.
    sppw_pkg::t_side r_s3;
    sppw_pkg::t_side r_s4;
    sppw_pkg::t_side r_s5;
    logic [DW-1:0]   r_xs3;
    logic [DW-1:0]   r_ys3;
    logic [DW-1:0]   r_xs4;
    logic [OW-1:0]   r_row4;
    logic [OW-1:0]   r_lin5;
    logic [OW-1:0]   n_off;

    always_comb begin
        case (r_s5.nbytes)
            sppw_pkg::BYTES_RGB888: n_off = r_lin5 + {r_lin5[OW-2:0], 1'b0};
            sppw_pkg::BYTES_RGBA:   n_off = {r_lin5[OW-3:0], 2'b00};
            default:                n_off = {r_lin5[OW-2:0], 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_xs3  <= r_scale ? w_qx : DW'(r_dly[DLY-1].x);
        r_ys3  <= r_scale ? w_qy : DW'(r_dly[DLY-1].y);
        r_xs4  <= r_xs3;
        r_row4 <= OW'(r_ys3) * OW'(r_tw);
        r_lin5 <= r_row4 + OW'(r_xs4);
        o_byte_offset <= n_off;
        o_write_data  <= r_s5.data;
        o_byte_count  <= r_s5.nbytes;
        if (!i_rst_n) begin
            r_s3     <= '0;
            r_s4     <= '0;
            r_s5     <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_s3     <= r_dly[DLY-1];
            r_s4     <= r_s3;
            r_s5     <= r_s4;
            o_strobe <= r_s5.vld && !r_s5.drop;
        end
    end

`ifndef SYNTHESIS
    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_byte_count == sppw_pkg::BYTES_RGB565 ||
                      o_byte_count == sppw_pkg::BYTES_RGB888 ||
                      o_byte_count == sppw_pkg::BYTES_RGBA))
        else $error("Illegal byte count on a write word.");

    a_rgb565_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_byte_count == sppw_pkg::BYTES_RGB565) |->
            (o_write_data[31:16] == 16'h0000 && o_byte_offset[0] == 1'b0))
        else $error("RGB565 word has upper data or odd offset.");

    a_rgba_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_byte_count == sppw_pkg::BYTES_RGBA) |->
            (o_byte_offset[1:0] == 2'b00))
        else $error("RGBA word offset is not word aligned.");

    a_idle_after_reset: assert property (@(posedge i_clk)
        (!i_rst_n) |=> !o_strobe)
        else $error("Write strobe right after reset.");
`endif

endmodule
`default_nettype wire
